### src/olse_pkg.sv
// ----------------------------------------------------------------------------
// olse_pkg
// Shared types and constants of the ordered list shift engine.
// ----------------------------------------------------------------------------
package olse_pkg;

	localparam int CAPACITY   = 16;
	localparam int DATA_WIDTH = 32;
	localparam int CNT_W      = $clog2(CAPACITY + 1);
	localparam int POS_W      = 5;
	localparam int CMP_W      = (CNT_W > POS_W) ? CNT_W : POS_W;

	typedef enum logic [1:0] {
		CMD_APPEND = 2'd0,
		CMD_INSERT = 2'd1,
		CMD_REMOVE = 2'd2,
		CMD_SEARCH = 2'd3
	} cmd_t;

	typedef logic [DATA_WIDTH-1:0] word_t;
	typedef logic [CNT_W-1:0]      cnt_t;

	typedef struct packed {
		cmd_t        command;
		logic [4:0]  position;
		logic [31:0] value;
	} in_beat_t;

	typedef struct packed {
		logic       success;
		logic [4:0] count;
	} out_beat_t;

	typedef struct packed {
		logic  do_ins;
		logic  do_rem;
		cnt_t  slot;
		cnt_t  count;
		word_t word;
	} cell_ctl_t;

endpackage

### src/ordered_list_shift_engine.sv
// ----------------------------------------------------------------------------
// ordered_list_shift_engine
// Fixed-capacity ordered list with append, insert, remove and search.
// ----------------------------------------------------------------------------
// The list is a row of cells that compare against the word and shift toward
// a neighbor together, and the first-match flag ripples combinationally along
// the row. One result beat leaves per command, through an output register, so
// a new command is accepted every cycle while the result is taken. No clearing
// pass follows reset.
module ordered_list_shift_engine
	import olse_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_beat_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_beat_t out_data
);

	cnt_t      count_q;
	logic      out_valid_q;
	out_beat_t out_q;

	logic                  accept;
	logic                  is_add;
	logic                  add_ok;
	logic                  found;
	logic                  ok;
	cnt_t                  slot;
	cnt_t                  count_d;
	cell_ctl_t             ctl;
	word_t                 cell_data [CAPACITY];
	logic [CAPACITY:0]     hit;

	assign in_ready  = !out_valid_q || out_ready;
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign is_add = (in_data.command == CMD_APPEND) || (in_data.command == CMD_INSERT);

	always_comb begin
		slot   = count_q;
		add_ok = 1'b0;
		if (in_data.command == CMD_INSERT) begin
			slot   = CNT_W'(in_data.position);
			add_ok = CMP_W'(in_data.position) <= CMP_W'(count_q);
		end else begin
			add_ok = 1'b1;
		end
		if (count_q == CNT_W'(CAPACITY)) begin
			add_ok = 1'b0;
		end
	end

	assign ctl.do_ins = accept && is_add && add_ok;
	assign ctl.do_rem = accept && (in_data.command == CMD_REMOVE);
	assign ctl.slot   = slot;
	assign ctl.count  = count_q;
	assign ctl.word   = DATA_WIDTH'(in_data.value);

	assign hit[0] = 1'b0;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		word_t left_w;
		word_t right_w;
		if (i == 0) begin : g_first
			assign left_w = '0;
		end else begin : g_mid_l
			assign left_w = cell_data[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign right_w = '0;
		end else begin : g_mid_r
			assign right_w = cell_data[i+1];
		end
		olse_cell u_cell (
			.clk     (clk),
			.idx     (CNT_W'(i)),
			.ctl     (ctl),
			.left    (left_w),
			.right   (right_w),
			.hit_in  (hit[i]),
			.data    (cell_data[i]),
			.hit_out (hit[i+1])
		);
	end

	assign found = hit[CAPACITY];

	always_comb begin
		ok      = 1'b0;
		count_d = count_q;
		case (in_data.command)
			CMD_APPEND, CMD_INSERT: begin
				ok = add_ok;
				if (add_ok) begin
					count_d = count_q + CNT_W'(1);
				end
			end
			CMD_REMOVE: begin
				ok = found;
				if (found) begin
					count_d = count_q - CNT_W'(1);
				end
			end
			CMD_SEARCH: begin
				ok = found;
			end
			default: begin
				ok = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q     <= count_d;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_q.success <= ok;
			out_q.count   <= 5'(count_d);
		end
	end

endmodule

### src/olse_cell.sv
// ----------------------------------------------------------------------------
// olse_cell
// One slot of the list: holds a word, compares it, and shifts with neighbors.
// ----------------------------------------------------------------------------
module olse_cell
	import olse_pkg::*;
(
	input  logic      clk,
	input  cnt_t      idx,
	input  cell_ctl_t ctl,
	input  word_t     left,
	input  word_t     right,
	input  logic      hit_in,
	output word_t     data,
	output logic      hit_out
);

	word_t data_q;
	logic  match;

	assign match   = (idx < ctl.count) && (data_q == ctl.word);
	assign hit_out = hit_in | match;
	assign data    = data_q;

	always_ff @(posedge clk) begin
		if (ctl.do_ins) begin
			if (idx > ctl.slot) begin
				data_q <= left;
			end else if (idx == ctl.slot) begin
				data_q <= ctl.word;
			end
		end else if (ctl.do_rem && hit_out) begin
			data_q <= right;
		end
	end

endmodule

### bench/ordered_list_shift_engine_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_list_shift_engine_tb
// Self-checking bench for the ordered list shift engine.
// ----------------------------------------------------------------------------
// A queue of commands feeds a valid/ready driver. A monitor keeps its own copy
// of the list, works out the status of every accepted command beat, and checks
// each status beat against the oldest prediction. Directed commands cover the
// empty and full list, out-of-range slots and duplicates. Random traffic then
// swings the list between empty and full. Both sides idle in bursts, the
// receiver holds off long enough to back up the input, and the sender waits
// twice for the list to settle before going on.
// ----------------------------------------------------------------------------
module ordered_list_shift_engine_tb;
	import olse_pkg::*;

	localparam int RANDOM_ITEMS = 480;
	localparam int TAIL_ITEMS   = 60;
	localparam int HOLD_AT      = 200;
	localparam int HOLD_CYCLES  = 300;
	localparam int WATCHDOG     = 2000;
	localparam int SETTLE       = 20;

	typedef struct {
		in_beat_t beat;
		int       gap;
		bit       drain;
	} queued_cmd_t;

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      in_valid  = 1'b0;
	logic      in_ready;
	in_beat_t  in_data   = '0;
	logic      out_valid;
	logic      out_ready = 1'b0;
	out_beat_t out_data;

	queued_cmd_t command_queue [$];
	out_beat_t   predicted_status [$];
	word_t       list_words [CAPACITY];
	int          list_count  = 0;
	int          n_in        = 0;
	int          n_out       = 0;
	int          err_count   = 0;
	int          gap_left    = 0;
	int          stall_left  = 0;
	int          hold_left   = 0;
	int          mode_left   = 0;
	int          idle_cycles = 0;
	bit          hold_done   = 1'b0;
	bit          rx_noisy    = 1'b0;
	bit          calm        = 1'b0;

	ordered_list_shift_engine u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	task automatic report_mismatch(input string what);
		$display("MISMATCH at %0t: %s", $time, what);
		err_count++;
	endtask

	task automatic queue_cmd(input cmd_t cmd, input int pos, input logic [31:0] value,
		input int gap, input bit drain);
		queued_cmd_t item;
		item.beat.command  = cmd;
		item.beat.position = 5'(pos);
		item.beat.value    = value;
		item.gap           = gap;
		item.drain         = drain;
		command_queue.insert(command_queue.size(), item);
	endtask

	function automatic out_beat_t list_status_after(input in_beat_t b);
		out_beat_t r;
		int        slot;
		int        hit;
		int        i;
		logic      ok;
		ok   = 1'b0;
		hit  = -1;
		slot = (b.command == CMD_APPEND) ? list_count : int'(b.position);
		case (b.command)
		CMD_APPEND, CMD_INSERT: begin
			if (slot <= list_count && list_count < CAPACITY) begin
				for (i = list_count; i > slot; i--)
					list_words[i] = list_words[i-1];
				list_words[slot] = word_t'(b.value);
				list_count++;
				ok = 1'b1;
			end
		end
		default: begin
			for (i = list_count - 1; i >= 0; i--)
				if (list_words[i] == word_t'(b.value))
					hit = i;
			ok = (hit >= 0);
			if (ok && b.command == CMD_REMOVE) begin
				for (i = hit; i + 1 < list_count; i++)
					list_words[i] = list_words[i+1];
				list_count--;
			end
		end
		endcase
		r.success = ok;
		r.count   = 5'(list_count);
		return r;
	endfunction

	// command driver
	always @(posedge clk or negedge arst_n) begin : drive_proc
		int in_flight;
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data  <= '0;
			gap_left <= 0;
			calm     <= 1'b0;
		end else begin
			calm      <= (command_queue.size() <= TAIL_ITEMS);
			in_flight = n_in - n_out + int'(in_valid && in_ready)
				- int'(out_valid && out_ready);
			if (!in_valid || in_ready) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					in_valid <= 1'b0;
				end else if (command_queue.size() == 0
					|| (command_queue[0].drain && in_flight != 0)) begin
					in_valid <= 1'b0;
				end else begin
					in_data  <= command_queue[0].beat;
					in_valid <= 1'b1;
					void'(command_queue.pop_front());
					gap_left <= (command_queue.size() != 0) ? command_queue[0].gap : 0;
				end
			end
		end
	end

	// status receiver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready  <= 1'b0;
			stall_left <= 0;
			hold_left  <= 0;
			hold_done  <= 1'b0;
			rx_noisy   <= 1'b0;
			mode_left  <= 0;
		end else begin
			mode_left <= (mode_left == 0) ? $urandom_range(20, 120) : mode_left - 1;
			if (mode_left == 0)
				rx_noisy <= ($urandom_range(0, 2) != 0);
			if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				out_ready <= 1'b0;
			end else if (!hold_done && n_in >= HOLD_AT) begin
				hold_left <= HOLD_CYCLES;
				hold_done <= 1'b1;
				out_ready <= 1'b0;
			end else if (calm) begin
				out_ready <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left <= stall_left - 1;
				out_ready  <= 1'b0;
			end else if (rx_noisy && $urandom_range(0, 5) == 0) begin
				stall_left <= $urandom_range(0, 16);
				out_ready  <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// predict on every command beat, check every status beat
	always @(posedge clk or negedge arst_n) begin : monitor_proc
		out_beat_t want;
		if (!arst_n) begin
			list_count = 0;
			n_in       <= 0;
			n_out      <= 0;
		end else begin
			if (in_valid && in_ready) begin
				predicted_status.insert(predicted_status.size(),
					list_status_after(in_data));
				n_in <= n_in + 1;
			end
			if (out_valid && out_ready) begin
				n_out <= n_out + 1;
				if (predicted_status.size() == 0) begin
					report_mismatch("status beat with no command outstanding");
				end else begin
					want = predicted_status.pop_front();
					if (out_data.success !== want.success)
						report_mismatch($sformatf("success %0b, expected %0b",
							out_data.success, want.success));
					if (out_data.count !== want.count)
						report_mismatch($sformatf("count %0d, expected %0d",
							out_data.count, want.count));
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles + 1 >= WATCHDOG) begin
			$display("watchdog: no beat accepted for %0d cycles", WATCHDOG);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin : stimulus
		word_t pool [8];
		cmd_t  cmd;
		int    n;
		int    k;
		int    pos;
		int    gap;
		bit    fill_bias;
		bit    noisy;
		logic [31:0] value;

		// empty list, slot past the end, duplicates, no match
		queue_cmd(CMD_SEARCH, 0, 32'h0000_0000, 0, 1'b0);
		queue_cmd(CMD_REMOVE, 3, 32'hFFFF_FFFF, 0, 1'b0);
		queue_cmd(CMD_INSERT, 1, 32'h1111_1111, 0, 1'b0);
		queue_cmd(CMD_INSERT, 0, 32'hFFFF_FFFF, 0, 1'b0);
		queue_cmd(CMD_APPEND, 31, 32'h0000_0000, 0, 1'b0);
		queue_cmd(CMD_APPEND, 0, 32'hFFFF_FFFF, 0, 1'b0);
		queue_cmd(CMD_INSERT, 1, 32'h8000_0001, 0, 1'b0);
		queue_cmd(CMD_REMOVE, 0, 32'hFFFF_FFFF, 0, 1'b0);
		queue_cmd(CMD_SEARCH, 0, 32'hFFFF_FFFF, 0, 1'b0);
		queue_cmd(CMD_REMOVE, 0, 32'h1234_5678, 0, 1'b0);
		queue_cmd(CMD_INSERT, 31, 32'h5555_5555, 0, 1'b0);
		// fill up, then overflow both ways
		for (n = 0; n < 13; n++)
			queue_cmd(CMD_APPEND, 0, $urandom(), 0, 1'b0);
		queue_cmd(CMD_APPEND, 0, 32'hAAAA_AAAA, 0, 1'b0);
		queue_cmd(CMD_INSERT, 16, 32'h5555_5555, 0, 1'b0);

		pool[0] = '0;
		pool[1] = '1;
		for (n = 2; n < 8; n++)
			pool[n] = $urandom();
		fill_bias = 1'b1;
		noisy     = 1'b0;
		for (n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 32 == 0)
				fill_bias = ~fill_bias;
			if (n % 48 == 0)
				noisy = ($urandom_range(0, 2) != 0);
			k = $urandom_range(0, 9);
			if (fill_bias)
				cmd = (k < 4) ? CMD_APPEND : (k < 7) ? CMD_INSERT : (k < 8) ? CMD_REMOVE
					: CMD_SEARCH;
			else
				cmd = (k < 1) ? CMD_APPEND : (k < 2) ? CMD_INSERT : (k < 7) ? CMD_REMOVE
					: CMD_SEARCH;
			pos   = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 31) : $urandom_range(0, 17);
			value = ($urandom_range(0, 7) == 0) ? $urandom() : pool[$urandom_range(0, 7)];
			gap   = (noisy && n < RANDOM_ITEMS - TAIL_ITEMS && $urandom_range(0, 5) == 0)
				? $urandom_range(1, 17) : 0;
			queue_cmd(cmd, pos, value, gap, (n == 100 || n == 350));
		end

		repeat (6) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		do
			@(negedge clk);
		while (command_queue.size() != 0 || in_valid || n_in != n_out);
		repeat (SETTLE) @(negedge clk);
		if (predicted_status.size() != 0)
			report_mismatch($sformatf("%0d status beats never arrived",
				predicted_status.size()));

		if (err_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

### filelist.f
src/olse_pkg.sv
src/olse_cell.sv
src/ordered_list_shift_engine.sv
bench/ordered_list_shift_engine_tb.sv
